// ===== hdl/env_sensor_compensation_unit_defines.svh =====
// Assertion macros shared by the compensation unit RTL.
`ifndef ENV_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on the rising clock edge, disabled while in reset.
`define ESCU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on the rising clock edge, including during reset.
`define ESCU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESCU_ASSERT(lbl, clk, rst, prop, msg)
`define ESCU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/escu_pkg.sv =====
`timescale 1ns / 1ps
package escu_pkg;

   localparam int CsrIdxW   = 3;
   localparam int DivStages = 32;

   // Register indexes of the calibration port
   typedef enum logic [CsrIdxW-1:0] {
      REG_CAL_TEMP    = 3'd0,
      REG_CAL_PRESS_A = 3'd1,
      REG_CAL_PRESS_B = 3'd2,
      REG_CAL_PRESS_C = 3'd3,
      REG_CAL_HUM     = 3'd4
   } csr_index_type;

   localparam logic [31:0] PressOffset   = 32'd64000;
   localparam logic [31:0] PressFull     = 32'd1048576;
   localparam logic [31:0] PressScale    = 32'd3125;
   localparam logic [31:0] HumOffset     = 32'd76800;
   localparam logic [31:0] HumRound      = 32'd16384;
   localparam logic [31:0] HumBias       = 32'd2097152;
   localparam logic [31:0] HumRoundH2    = 32'd8192;
   localparam logic [31:0] HumClamp      = 32'd419430400;
   localparam logic [31:0] Half15        = 32'd32768;
   localparam logic [31:0] TempRound     = 32'd128;

   // Calibration words as unpacked from the registers
   typedef struct packed {
      logic [15:0] t1, t2, t3;
      logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [7:0]  h1;
      logic [15:0] h2;
      logic [7:0]  h3;
      logic [11:0] h4, h5;
      logic [7:0]  h6;
   } cal_type;

   // Division request from the front end
   typedef struct packed {
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   // Finished fields and pressure flags that ride along the divider
   typedef struct packed {
      logic [15:0] temp;
      logic [16:0] hum;
      logic        dbl;
      logic        zero;
   } side_type;

   function automatic logic [31:0] asr(logic [31:0] x, int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx12(logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

   function automatic logic [31:0] sx8(logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage

// ===== hdl/escu_if.sv =====
`timescale 1ns / 1ps
interface escu_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temp;
   logic [19:0] raw_pressure;
   logic [15:0] raw_humidity;
   modport source (output valid, raw_temp, raw_pressure, raw_humidity, input ready);
   modport sink   (input valid, raw_temp, raw_pressure, raw_humidity, output ready);
endinterface

interface escu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] temp_centideg;
   logic [31:0]        pressure_pa;
   logic [16:0]        humidity_q10;
   modport source (output valid, temp_centideg, pressure_pa, humidity_q10, input ready);
   modport sink   (input valid, temp_centideg, pressure_pa, humidity_q10, output ready);
endinterface

interface escu_csr_if;
   logic                             valid;
   logic                             ready;
   logic [escu_pkg::CsrIdxW-1:0]     index;
   logic [63:0]                      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/escu_front.sv =====
`timescale 1ns / 1ps
module escu_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [19:0]            raw_temp,
   input  logic [19:0]            raw_pressure,
   input  logic [15:0]            raw_humidity,
   input  escu_pkg::cal_type      cal,
   output logic                   out_valid,
   output escu_pkg::div_req_type  out_div,
   output escu_pkg::side_type     out_side
);

   localparam int Stages = 13;

   logic [Stages-1:0] v_ff;

   logic [31:0] ta1_ff, td1_ff;
   logic [19:0] adcp1_ff, adcp2_ff, adcp3_ff, adcp4_ff, adcp5_ff, adcp6_ff, adcp7_ff,
                adcp8_ff;
   logic [15:0] adch1_ff, adch2_ff, adch3_ff, adch4_ff, adch5_ff, adch6_ff;
   logic [31:0] ta2_ff, dd2_ff;
   logic [31:0] ta3_ff, tb3_ff;
   logic [31:0] tf4_ff;
   logic [15:0] temp5_ff, temp6_ff, temp7_ff, temp8_ff, temp9_ff, temp10_ff, temp11_ff,
                temp12_ff, temp13_ff;
   logic [31:0] pa5_ff, ha5_ff;
   logic [31:0] q6_ff, pa56_ff, p2a6_ff, hd6_ff, hb6_ff, hc6_ff;
   logic [31:0] qb7_ff, p3q7_ff, pa57_ff, p2a7_ff, he7_ff, hb7_ff, hc7_ff;
   logic [31:0] pb8_ff, pa8_ff, hd8_ff, he8_ff;
   logic [31:0] pv9_ff, pn9_ff, hb9_ff, he9_ff;
   logic [31:0] hc10_ff, hc11_ff, hc12_ff, hs11_ff, hm12_ff;
   escu_pkg::div_req_type div10_ff, div11_ff, div12_ff, div13_ff;
   logic        dbl10_ff, dbl11_ff, dbl12_ff, dbl13_ff;
   logic        zero10_ff, zero11_ff, zero12_ff, zero13_ff;
   logic [16:0] hum13_ff;

   logic [31:0] he13_in;
   logic [31:0] hcl13_in;
   logic [31:0] pn_in;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[Stages-2:0], in_valid};
      end
   end

   // Stage 1 to 5: temperature and fine temperature
   always_ff @(posedge clock) begin
      if (en) begin
         ta1_ff   <= 32'(raw_temp >> 3) - 32'({cal.t1, 1'b0});
         td1_ff   <= 32'(raw_temp >> 4) - 32'(cal.t1);
         adcp1_ff <= raw_pressure;
         adch1_ff <= raw_humidity;

         ta2_ff   <= escu_pkg::asr(ta1_ff * escu_pkg::sx16(cal.t2), 11);
         dd2_ff   <= escu_pkg::asr(td1_ff * td1_ff, 12);
         adcp2_ff <= adcp1_ff;
         adch2_ff <= adch1_ff;

         ta3_ff   <= ta2_ff;
         tb3_ff   <= escu_pkg::asr(dd2_ff * escu_pkg::sx16(cal.t3), 14);
         adcp3_ff <= adcp2_ff;
         adch3_ff <= adch2_ff;

         tf4_ff   <= ta3_ff + tb3_ff;
         adcp4_ff <= adcp3_ff;
         adch4_ff <= adch3_ff;

         temp5_ff <= 16'(escu_pkg::asr((tf4_ff << 2) + tf4_ff + escu_pkg::TempRound, 8));
         pa5_ff   <= escu_pkg::asr(tf4_ff, 1) - escu_pkg::PressOffset;
         ha5_ff   <= tf4_ff - escu_pkg::HumOffset;
         adcp5_ff <= adcp4_ff;
         adch5_ff <= adch4_ff;
      end
   end

   // Stage 6 to 9: pressure divisor and numerator, humidity terms
   always_ff @(posedge clock) begin
      if (en) begin
         q6_ff    <= escu_pkg::asr(pa5_ff, 2) * escu_pkg::asr(pa5_ff, 2);
         pa56_ff  <= pa5_ff * escu_pkg::sx16(cal.p5);
         p2a6_ff  <= escu_pkg::sx16(cal.p2) * pa5_ff;
         hd6_ff   <= escu_pkg::sx12(cal.h5) * ha5_ff;
         hb6_ff   <= ha5_ff * escu_pkg::sx8(cal.h6);
         hc6_ff   <= ha5_ff * 32'(cal.h3);
         temp6_ff <= temp5_ff;
         adcp6_ff <= adcp5_ff;
         adch6_ff <= adch5_ff;

         qb7_ff   <= escu_pkg::asr(q6_ff, 11) * escu_pkg::sx16(cal.p6);
         p3q7_ff  <= escu_pkg::sx16(cal.p3) * escu_pkg::asr(q6_ff, 13);
         pa57_ff  <= pa56_ff;
         p2a7_ff  <= p2a6_ff;
         he7_ff   <= escu_pkg::asr((32'(adch6_ff) << 14) - (escu_pkg::sx12(cal.h4) << 20)
                                   - hd6_ff + escu_pkg::HumRound, 15);
         hb7_ff   <= escu_pkg::asr(hb6_ff, 10);
         hc7_ff   <= escu_pkg::asr(hc6_ff, 11) + escu_pkg::Half15;
         temp7_ff <= temp6_ff;
         adcp7_ff <= adcp6_ff;

         pb8_ff   <= escu_pkg::asr(qb7_ff + (pa57_ff << 1), 2)
                     + (escu_pkg::sx16(cal.p4) << 16);
         pa8_ff   <= escu_pkg::asr(escu_pkg::asr(p3q7_ff, 3) + escu_pkg::asr(p2a7_ff, 1), 18);
         hd8_ff   <= escu_pkg::asr(hb7_ff * hc7_ff, 10) + escu_pkg::HumBias;
         he8_ff   <= he7_ff;
         temp8_ff <= temp7_ff;
         adcp8_ff <= adcp7_ff;

         pv9_ff   <= escu_pkg::asr((escu_pkg::Half15 + pa8_ff) * 32'(cal.p1), 15);
         pn9_ff   <= ((escu_pkg::PressFull - 32'(adcp8_ff)) - escu_pkg::asr(pb8_ff, 12))
                     * escu_pkg::PressScale;
         hb9_ff   <= escu_pkg::asr(hd8_ff * escu_pkg::sx16(cal.h2) + escu_pkg::HumRoundH2, 14);
         he9_ff   <= he8_ff;
         temp9_ff <= temp8_ff;
      end
   end

   // Double before dividing when the top bit is clear, after dividing otherwise
   assign pn_in = pn9_ff[31] ? pn9_ff : (pn9_ff << 1);

   // Humidity: final correction and clamp
   assign he13_in = hc12_ff - escu_pkg::asr(hm12_ff, 4);
   always_comb begin
      if (he13_in[31]) begin
         hcl13_in = '0;
      end else if (he13_in > escu_pkg::HumClamp) begin
         hcl13_in = escu_pkg::HumClamp;
      end else begin
         hcl13_in = he13_in;
      end
   end

   // Stage 10 to 13: humidity product chain, hold the division request
   always_ff @(posedge clock) begin
      if (en) begin
         hc10_ff           <= he9_ff * hb9_ff;
         div10_ff.dividend <= pn_in;
         div10_ff.divisor  <= pv9_ff;
         dbl10_ff          <= pn9_ff[31];
         zero10_ff         <= (pv9_ff == '0);
         temp10_ff         <= temp9_ff;

         hs11_ff   <= escu_pkg::asr(hc10_ff, 15) * escu_pkg::asr(hc10_ff, 15);
         hc11_ff   <= hc10_ff;
         div11_ff  <= div10_ff;
         dbl11_ff  <= dbl10_ff;
         zero11_ff <= zero10_ff;
         temp11_ff <= temp10_ff;

         hm12_ff   <= escu_pkg::asr(hs11_ff, 7) * 32'(cal.h1);
         hc12_ff   <= hc11_ff;
         div12_ff  <= div11_ff;
         dbl12_ff  <= dbl11_ff;
         zero12_ff <= zero11_ff;
         temp12_ff <= temp11_ff;

         hum13_ff  <= 17'(hcl13_in >> 12);
         div13_ff  <= div12_ff;
         dbl13_ff  <= dbl12_ff;
         zero13_ff <= zero12_ff;
         temp13_ff <= temp12_ff;
      end
   end

   assign out_valid     = v_ff[Stages-1];
   assign out_div       = div13_ff;
   assign out_side.temp = temp13_ff;
   assign out_side.hum  = hum13_ff;
   assign out_side.dbl  = dbl13_ff;
   assign out_side.zero = zero13_ff;

endmodule

// ===== hdl/escu_div.sv =====
`timescale 1ns / 1ps
module escu_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  escu_pkg::div_req_type  in_div,
   input  escu_pkg::side_type     in_side,
   output logic                   out_valid,
   output logic [31:0]            quotient,
   output escu_pkg::side_type     out_side
);

   localparam int N = escu_pkg::DivStages;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dq;
      logic [31:0] divisor;
   } div_stage_type;

   div_stage_type      st_ff [N];
   div_stage_type      st_in [N];
   escu_pkg::side_type side_ff [N];
   logic [N-1:0]       v_ff;

   // One quotient bit per stage: shift in a dividend bit, subtract if it fits
   always_comb begin
      div_stage_type src;
      logic [32:0]   trial;
      logic          fits;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            src.rem     = '0;
            src.dq      = in_div.dividend;
            src.divisor = in_div.divisor;
         end else begin
            src = st_ff[k-1];
         end
         trial            = {src.rem, src.dq[31]};
         fits             = (trial >= {1'b0, src.divisor});
         st_in[k].rem     = fits ? 32'(trial - {1'b0, src.divisor}) : trial[31:0];
         st_in[k].dq      = {src.dq[30:0], fits};
         st_in[k].divisor = src.divisor;
      end
   end

   // Advance the stages
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            st_ff[k]   <= st_in[k];
            side_ff[k] <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[N-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[N-1];
   assign quotient  = st_ff[N-1].dq;
   assign out_side  = side_ff[N-1];

endmodule

// ===== hdl/escu_back.sv =====
`timescale 1ns / 1ps
module escu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [31:0]         quotient,
   input  escu_pkg::side_type  in_side,
   input  escu_pkg::cal_type   cal,
   output logic                out_valid,
   output logic [15:0]         temp,
   output logic [31:0]         pressure,
   output logic [16:0]         hum
);

   localparam int Stages = 4;

   logic [Stages-1:0] v_ff;
   logic [31:0] p1_ff, p2_ff, p3_ff;
   logic [31:0] sq2_ff, pb2_ff, a3_ff, b3_ff, pres4_ff;
   logic [15:0] temp1_ff, temp2_ff, temp3_ff, temp4_ff;
   logic [16:0] hum1_ff, hum2_ff, hum3_ff, hum4_ff;
   logic        zero1_ff, zero2_ff, zero3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[Stages-2:0], in_valid};
      end
   end

   // Scale the quotient, then apply the second-order pressure correction
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= in_side.dbl ? (quotient << 1) : quotient;
         zero1_ff <= in_side.zero;
         temp1_ff <= in_side.temp;
         hum1_ff  <= in_side.hum;

         sq2_ff   <= (p1_ff >> 3) * (p1_ff >> 3);
         pb2_ff   <= (p1_ff >> 2) * escu_pkg::sx16(cal.p8);
         p2_ff    <= p1_ff;
         zero2_ff <= zero1_ff;
         temp2_ff <= temp1_ff;
         hum2_ff  <= hum1_ff;

         a3_ff    <= escu_pkg::asr(escu_pkg::sx16(cal.p9) * (sq2_ff >> 13), 12);
         b3_ff    <= escu_pkg::asr(pb2_ff, 13);
         p3_ff    <= p2_ff;
         zero3_ff <= zero2_ff;
         temp3_ff <= temp2_ff;
         hum3_ff  <= hum2_ff;

         pres4_ff <= zero3_ff ? '0
                     : p3_ff + escu_pkg::asr(a3_ff + b3_ff + escu_pkg::sx16(cal.p7), 4);
         temp4_ff <= temp3_ff;
         hum4_ff  <= hum3_ff;
      end
   end

   assign out_valid = v_ff[Stages-1];
   assign temp      = temp4_ff;
   assign pressure  = pres4_ff;
   assign hum       = hum4_ff;

endmodule

// ===== hdl/env_sensor_compensation_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake     Contents
// req_if   in   valid/ready   raw_temp, raw_pressure, raw_humidity
// rsp_if   out  valid/ready   temp_centideg, pressure_pa, humidity_q10
// csr_if   in   valid/ready   index, data (calibration words)
//
// One request per cycle while no result is stalled; 49 register stages
// (13 front, 32 divider, 4 back) lie between a request and its result.
// The 32-stage restoring divider sets the depth, one quotient bit per stage.
// Synchronous reset clears valid bits and all calibration registers to zero.
// A stalled result holds the whole pipeline; csr writes are always taken.
`include "env_sensor_compensation_unit_defines.svh"
module env_sensor_compensation_unit (
   input logic          clock,
   input logic          reset,
   escu_req_if.sink     req_if,
   escu_rsp_if.source   rsp_if,
   escu_csr_if.sink     csr_if
);

   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff, cal_press_b_ff, cal_hum_ff;
   logic [15:0] cal_press_c_ff;
   escu_pkg::cal_type     cal;
   logic                  en;
   logic                  f_valid, d_valid, b_valid;
   escu_pkg::div_req_type f_div;
   escu_pkg::side_type    f_side, d_side;
   logic [31:0]           d_quo;
   logic [15:0]           b_temp;
   logic [31:0]           b_pres;
   logic [16:0]           b_hum;

   // Write calibration registers; drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_press_c_ff <= '0;
         cal_hum_ff     <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            escu_pkg::REG_CAL_TEMP:    cal_temp_ff    <= csr_if.data[47:0];
            escu_pkg::REG_CAL_PRESS_A: cal_press_a_ff <= csr_if.data;
            escu_pkg::REG_CAL_PRESS_B: cal_press_b_ff <= csr_if.data;
            escu_pkg::REG_CAL_PRESS_C: cal_press_c_ff <= csr_if.data[15:0];
            escu_pkg::REG_CAL_HUM:     cal_hum_ff     <= csr_if.data;
            default: begin
            end
         endcase
      end
   end
   assign csr_if.ready = 1'b1;

   // Unpack calibration fields
   always_comb begin
      cal.t1 = cal_temp_ff[15:0];
      cal.t2 = cal_temp_ff[31:16];
      cal.t3 = cal_temp_ff[47:32];
      cal.p1 = cal_press_a_ff[15:0];
      cal.p2 = cal_press_a_ff[31:16];
      cal.p3 = cal_press_a_ff[47:32];
      cal.p4 = cal_press_a_ff[63:48];
      cal.p5 = cal_press_b_ff[15:0];
      cal.p6 = cal_press_b_ff[31:16];
      cal.p7 = cal_press_b_ff[47:32];
      cal.p8 = cal_press_b_ff[63:48];
      cal.p9 = cal_press_c_ff;
      cal.h1 = cal_hum_ff[7:0];
      cal.h2 = cal_hum_ff[23:8];
      cal.h3 = cal_hum_ff[31:24];
      cal.h4 = cal_hum_ff[43:32];
      cal.h5 = cal_hum_ff[55:44];
      cal.h6 = cal_hum_ff[63:56];
   end

   // Advance everything unless a finished result is held
   assign en           = !b_valid || rsp_if.ready;
   assign req_if.ready = en;

   escu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_if.valid),
      .raw_temp     (req_if.raw_temp),
      .raw_pressure (req_if.raw_pressure),
      .raw_humidity (req_if.raw_humidity),
      .cal          (cal),
      .out_valid    (f_valid),
      .out_div      (f_div),
      .out_side     (f_side)
   );

   escu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_div    (f_div),
      .in_side   (f_side),
      .out_valid (d_valid),
      .quotient  (d_quo),
      .out_side  (d_side)
   );

   escu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .quotient  (d_quo),
      .in_side   (d_side),
      .cal       (cal),
      .out_valid (b_valid),
      .temp      (b_temp),
      .pressure  (b_pres),
      .hum       (b_hum)
   );

   assign rsp_if.valid         = b_valid;
   assign rsp_if.temp_centideg = $signed(b_temp);
   assign rsp_if.pressure_pa   = b_pres;
   assign rsp_if.humidity_q10  = b_hum;

   `ESCU_ASSERT(a_take_stall, clock, reset, (req_if.valid && req_if.ready) |-> en, "take in stall")
   `ESCU_ASSERT_ALWAYS(a_reset_out, clock, reset |=> !rsp_if.valid, "valid after reset")
   `ESCU_ASSERT(a_hum_range, clock, reset, rsp_if.valid |-> (b_hum <= 17'd102400), "humidity over")
   `ESCU_ASSERT(a_csr_ready, clock, reset, csr_if.ready, "calibration port not ready")

endmodule
